// ===== rtl/core/si2dec_pkg.sv =====
// Shared types and constants for the signed decimal printer.
package si2dec_pkg;

    localparam int ValueWidth = 32;
    localparam int NumDigits  = 10;
    localparam int DigitWidth = 4;
    localparam int BcdWidth   = NumDigits * DigitWidth;
    localparam int CharWidth  = 8;

    localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharCr    = 8'h0D;
    localparam logic [CharWidth-1:0] CharLf    = 8'h0A;

    typedef logic [NumDigits-1:0][DigitWidth-1:0] bcd_digits_t;

    typedef struct packed {
        logic                  start;
        logic [ValueWidth-1:0] magnitude;
    } bcd_req_t;

    typedef struct packed {
        logic        done;
        bcd_digits_t digits;
    } bcd_rsp_t;

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Top level of the signed decimal printer: sequencer, digit shifter and output register.
//
//  Channel | Ports                              | Direction | Moves
//  --------+------------------------------------+-----------+------------------------------
//  input   | s_valid, s_ready, s_value[31:0]    | in        | one signed integer per transfer
//  result  | m_valid, m_ready, m_character, m_last | out    | one ASCII character per transfer
//
// An item passes through an accept step, the shift-add-3 converter loop, a hand-over of the
// digits, a strip of leading zeros (one digit per cycle, plus a step to move on), and then
// the emission of characters, one per cycle while m_ready is high.
// Stripping and emitting trade off digit for digit, and the converter loop takes the largest
// part of an item's time.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A stalled sink holds the character in the output register and pauses the sequencer in its output states.
module signed_int_to_decimal_ascii (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [si2dec_pkg::ValueWidth-1:0] s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [si2dec_pkg::CharWidth-1:0]      m_character,
    output logic                                  m_last
);

    localparam int NdigWidth = $clog2(si2dec_pkg::NumDigits + 1);

    // Sequencer states.
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StConv  = 3'd1;
    localparam logic [2:0] StTrim  = 3'd2;
    localparam logic [2:0] StSign  = 3'd3;
    localparam logic [2:0] StDigit = 3'd4;
    localparam logic [2:0] StCr    = 3'd5;
    localparam logic [2:0] StLf    = 3'd6;

    logic [2:0]                       state_reg, state_next;
    logic                             neg_reg, neg_next;
    si2dec_pkg::bcd_digits_t          digits_reg, digits_next;
    logic [NdigWidth-1:0]             ndig_reg, ndig_next;
    logic                             m_valid_reg, m_valid_next;
    logic [si2dec_pkg::CharWidth-1:0] m_character_reg, m_character_next;
    logic                             m_last_reg, m_last_next;

    si2dec_pkg::bcd_req_t             bcd_req;
    si2dec_pkg::bcd_rsp_t             bcd_rsp;
    logic                             in_xfer;
    logic                             out_load;
    logic [si2dec_pkg::DigitWidth-1:0] top_digit;
    si2dec_pkg::bcd_digits_t          digits_shifted;

    assign s_ready = (state_reg == StIdle);
    assign in_xfer = s_valid && s_ready;

    // The magnitude is formed unsigned, so the most negative value keeps all its digits.
    assign bcd_req.start     = in_xfer;
    assign bcd_req.magnitude = s_value[si2dec_pkg::ValueWidth-1]
                             ? (~s_value + 1'b1) : s_value;

    si2dec_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bcd_req),
        .rsp     (bcd_rsp)
    );

    assign top_digit      = digits_reg[si2dec_pkg::NumDigits-1];
    assign digits_shifted = si2dec_pkg::bcd_digits_t'(
        {digits_reg[si2dec_pkg::NumDigits-2:0], {si2dec_pkg::DigitWidth{1'b0}}});

    // A new character may enter the output register when it is empty or being taken.
    assign out_load = !m_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        digits_next      = digits_reg;
        ndig_next        = ndig_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            StIdle: begin
                if (in_xfer) begin
                    neg_next   = s_value[si2dec_pkg::ValueWidth-1];
                    state_next = StConv;
                end
            end
            StConv: begin
                if (bcd_rsp.done) begin
                    digits_next = bcd_rsp.digits;
                    ndig_next   = NdigWidth'(si2dec_pkg::NumDigits);
                    state_next  = StTrim;
                end
            end
            StTrim: begin
                // Drop leading zeros, but always keep one digit so zero prints as '0'.
                if (top_digit == '0 && ndig_reg != NdigWidth'(1)) begin
                    digits_next = digits_shifted;
                    ndig_next   = ndig_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? StSign : StDigit;
                end
            end
            StSign: begin
                if (out_load) begin
                    m_valid_next     = 1'b1;
                    m_character_next = si2dec_pkg::CharMinus;
                    m_last_next      = 1'b0;
                    state_next       = StDigit;
                end
            end
            StDigit: begin
                if (out_load) begin
                    m_valid_next     = 1'b1;
                    m_character_next = si2dec_pkg::CharZero
                                     + si2dec_pkg::CharWidth'(top_digit);
                    m_last_next      = 1'b0;
                    digits_next      = digits_shifted;
                    ndig_next        = ndig_reg - 1'b1;
                    if (ndig_reg == NdigWidth'(1)) begin
                        state_next = StCr;
                    end
                end
            end
            StCr: begin
                if (out_load) begin
                    m_valid_next     = 1'b1;
                    m_character_next = si2dec_pkg::CharCr;
                    m_last_next      = 1'b0;
                    state_next       = StLf;
                end
            end
            StLf: begin
                // The line feed closes the run; the next item may be taken while it waits.
                if (out_load) begin
                    m_valid_next     = 1'b1;
                    m_character_next = si2dec_pkg::CharLf;
                    m_last_next      = 1'b1;
                    state_next       = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg         <= neg_next;
        digits_reg      <= digits_next;
        ndig_reg        <= ndig_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

endmodule

// ===== rtl/core/si2dec_bcd.sv =====
// Iterative binary to BCD converter using one shift-add-3 step per cycle.
module si2dec_bcd (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  si2dec_pkg::bcd_req_t req,
    output si2dec_pkg::bcd_rsp_t rsp
);

    localparam int CntWidth = $clog2(si2dec_pkg::ValueWidth);

    logic [si2dec_pkg::ValueWidth-1:0] bin_reg, bin_next;
    si2dec_pkg::bcd_digits_t           bcd_reg, bcd_next;
    si2dec_pkg::bcd_digits_t           adj;
    logic [si2dec_pkg::BcdWidth-1:0]   adj_flat;
    logic [CntWidth-1:0]               cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;

    // Digits of five or more get three added before the shift.
    always_comb begin
        for (int i = 0; i < si2dec_pkg::NumDigits; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        adj_flat = adj;
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            bin_next  = req.magnitude;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bin_next = {bin_reg[si2dec_pkg::ValueWidth-2:0], 1'b0};
            bcd_next = si2dec_pkg::bcd_digits_t'(
                {adj_flat[si2dec_pkg::BcdWidth-2:0], bin_reg[si2dec_pkg::ValueWidth-1]});
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntWidth'(si2dec_pkg::ValueWidth - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.digits = bcd_reg;

endmodule

// ===== rtl/core/si2dec_checker.sv =====
// Port-level checker for the signed decimal printer, bound to the top level.
module si2dec_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic [si2dec_pkg::ValueWidth-1:0]     s_value,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [si2dec_pkg::CharWidth-1:0]      m_character,
    input logic                                  m_last
);

    // A stalled character holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("result changed while stalled");

    // Only a line feed closes a run.
    a_last_is_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_character == si2dec_pkg::CharLf)
        else $error("last flag on a character other than line feed");

    // The line feed is ready right after the carriage return transfer.
    a_cr_then_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_character == si2dec_pkg::CharCr
        |=> m_valid && m_last)
        else $error("carriage return not followed by line feed");

    // After an input transfer the block is busy.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an input transfer");

    // No new item is taken while a run is still open.
    a_no_accept_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("ready high in the middle of a run");

endmodule

bind signed_int_to_decimal_ascii si2dec_checker u_si2dec_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_value     (s_value),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_last      (m_last)
);
